FILE: design/skvt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// skvt_pkg
// Types and constants shared by the sorted key/value table.
// ---------------------------------------------------------------------------
package skvt_pkg;

    localparam int CAPACITY   = 64;
    localparam int WORD_W     = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int COUNT_W    = 7;
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_LOWER  = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t opcode;
        word_t   key;
        word_t   value;
    } cmd_t;

    typedef struct packed {
        logic               hit;
        word_t              result_value;
        logic               dropped_full;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD,
        ST_OUT
    } state_t;

    // broadcast to every cell
    typedef struct packed {
        logic  cmp;
        logic  ins_over;
        logic  ins_new;
        logic  rem;
        word_t key;
        word_t value;
    } cell_ctrl_t;

    // reduced from the cell row
    typedef struct packed {
        logic found;
        logic any_sel;
    } cell_stat_t;

endpackage
`default_nettype wire

FILE: design/sorted_key_value_table.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_key_value_table
// Up to CAPACITY signed key/value pairs kept in ascending key order in a row
// of slot cells, with insert, remove, exact lookup and lower-bound lookup.
// ---------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Every command
// steps through a compare state, in which all slots compare their key against
// the command key in parallel, an update state, in which the row shifts
// pairs to their neighbors (or overwrites a value) while the group registers
// of the value or-tree are loaded, and an output state, in which the result
// sits on the result port with done high. done lasts exactly one cycle and
// the result cannot be held off, so the receiver must take it then. busy is
// high in compare and update and low in that result cycle, so a new command
// may be issued there. After reset the table is empty and ready at once.
// ---------------------------------------------------------------------------
module sorted_key_value_table
    import skvt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire cmd_t command,
    output logic      busy,
    output logic      done,
    output rsp_t      result
);

    cell_ctrl_t          ctrl;
    cell_stat_t          stat;
    logic                upd;
    logic                val_en;
    logic [CNT_W-1:0]    count;
    logic                hit;
    logic                dropped_full;
    word_t               result_value;
    word_t               cell_key [CAPACITY];
    word_t               cell_val [CAPACITY];
    logic [CAPACITY-1:0] cell_less;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_sel;

    skvt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .stat         (stat),
        .busy         (busy),
        .done         (done),
        .ctrl         (ctrl),
        .upd          (upd),
        .val_en       (val_en),
        .count        (count),
        .hit          (hit),
        .dropped_full (dropped_full)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic  occ;
        logic  left_less;
        word_t left_key;
        word_t left_val;
        word_t right_key;
        word_t right_val;

        assign occ = (CNT_W'(i) < count);

        if (i == 0)
        begin : g_first
            assign left_less = 1'b1;
            assign left_key  = cell_key[i];
            assign left_val  = cell_val[i];
        end
        else
        begin : g_mid
            assign left_less = cell_less[i-1];
            assign left_key  = cell_key[i-1];
            assign left_val  = cell_val[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_key = cell_key[i];
            assign right_val = cell_val[i];
        end
        else
        begin : g_inner
            assign right_key = cell_key[i+1];
            assign right_val = cell_val[i+1];
        end

        skvt_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occ       (occ),
            .left_less (left_less),
            .left_key  (left_key),
            .left_val  (left_val),
            .right_key (right_key),
            .right_val (right_val),
            .key       (cell_key[i]),
            .val       (cell_val[i]),
            .less      (cell_less[i]),
            .eq        (cell_eq[i]),
            .sel       (cell_sel[i])
        );
    end

    assign stat.found   = |cell_eq;
    assign stat.any_sel = |cell_sel;

    skvt_gather u_gather (
        .clk          (clk),
        .en           (upd),
        .val_en       (val_en),
        .sel          (cell_sel),
        .vals         (cell_val),
        .result_value (result_value)
    );

    assign result.hit          = hit;
    assign result.result_value = result_value;
    assign result.dropped_full = dropped_full;
    assign result.entry_count  = COUNT_W'(count);

endmodule
`default_nettype wire

FILE: design/skvt_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// skvt_cell
// One table slot: holds a pair, compares it against the command key and
// shifts pairs to or from its neighbors on insert and remove.
// ---------------------------------------------------------------------------
module skvt_cell
    import skvt_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occ,
    input  wire logic       left_less,
    input  wire word_t      left_key,
    input  wire word_t      left_val,
    input  wire word_t      right_key,
    input  wire word_t      right_val,
    output word_t           key,
    output word_t           val,
    output logic            less,
    output logic            eq,
    output logic            sel
);

    word_t key_reg;
    word_t key_next;
    word_t val_reg;
    word_t val_next;
    logic  less_reg;
    logic  less_next;
    logic  eq_reg;
    logic  eq_next;
    logic  at_pos;

    // first slot whose key is not below the command key
    assign at_pos = !less_reg && left_less;

    always_comb
    begin
        less_next = less_reg;
        eq_next   = eq_reg;
        key_next  = key_reg;
        val_next  = val_reg;
        if (ctrl.cmp)
        begin
            less_next = occ && (key_reg < ctrl.key);
            eq_next   = occ && (key_reg == ctrl.key);
        end
        if (ctrl.ins_over && eq_reg)
        begin
            val_next = ctrl.value;
        end
        if (ctrl.ins_new && !less_reg)
        begin
            if (at_pos)
            begin
                key_next = ctrl.key;
                val_next = ctrl.value;
            end
            else
            begin
                key_next = left_key;
                val_next = left_val;
            end
        end
        if (ctrl.rem && !less_reg)
        begin
            key_next = right_key;
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        val_reg  <= val_next;
        less_reg <= less_next;
        eq_reg   <= eq_next;
    end

    assign key  = key_reg;
    assign val  = val_reg;
    assign less = less_reg;
    assign eq   = eq_reg;
    assign sel  = occ && at_pos;

endmodule
`default_nettype wire

FILE: design/skvt_gather.sv
`default_nettype none
// ---------------------------------------------------------------------------
// skvt_gather
// Picks the value of the selected slot through a registered two-level
// or-tree, one register per group of slots.
// ---------------------------------------------------------------------------
module skvt_gather
    import skvt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic                val_en,
    input  wire logic [CAPACITY-1:0] sel,
    input  wire word_t               vals [CAPACITY],
    output word_t                    result_value
);

    word_t grp_reg  [NUM_GROUPS];
    word_t grp_next [NUM_GROUPS];

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_next[g] = grp_reg[g];
            if (en)
            begin
                grp_next[g] = '0;
                for (int j = 0; j < GROUP_SIZE; j++)
                begin
                    if (g * GROUP_SIZE + j < CAPACITY)
                    begin
                        if (val_en && sel[g * GROUP_SIZE + j])
                        begin
                            grp_next[g] = grp_next[g] | vals[g * GROUP_SIZE + j];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    always_comb
    begin
        result_value = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            result_value = result_value | grp_reg[g];
        end
    end

endmodule
`default_nettype wire

FILE: design/skvt_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// skvt_ctrl
// Command sequencer: latches a command, steps the cell row through compare
// and update, keeps the pair count and builds the status of the result.
// ---------------------------------------------------------------------------
module skvt_ctrl
    import skvt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire cmd_t       command,
    input  wire cell_stat_t stat,
    output logic            busy,
    output logic            done,
    output cell_ctrl_t      ctrl,
    output logic            upd,
    output logic            val_en,
    output logic [CNT_W-1:0] count,
    output logic            hit,
    output logic            dropped_full
);

    state_t           state_reg;
    state_t           state_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             hit_reg;
    logic             hit_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic             accept;
    logic             full;
    logic             is_insert;

    assign accept    = start && !busy;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign is_insert = (cmd_reg.opcode == OP_INSERT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start) state_next = ST_CMP;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_OUT;
            ST_OUT:  state_next = start ? ST_CMP : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy = 1'b0;
        done = 1'b0;
        upd  = 1'b0;
        case (state_reg)
            ST_IDLE: busy = 1'b0;
            ST_CMP:  busy = 1'b1;
            ST_UPD:
            begin
                busy = 1'b1;
                upd  = 1'b1;
            end
            ST_OUT:  done = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    always_comb
    begin
        ctrl.cmp      = (state_reg == ST_CMP);
        ctrl.ins_over = upd && is_insert && stat.found;
        ctrl.ins_new  = upd && is_insert && !stat.found && !full;
        ctrl.rem      = upd && (cmd_reg.opcode == OP_REMOVE) && stat.found;
        ctrl.key      = cmd_reg.key;
        ctrl.value    = cmd_reg.value;
        val_en        = ((cmd_reg.opcode == OP_LOOKUP) && stat.found)
                        || (cmd_reg.opcode == OP_LOWER);
    end

    always_comb
    begin
        cmd_next     = accept ? command : cmd_reg;
        count_next   = count_reg;
        hit_next     = hit_reg;
        dropped_next = dropped_reg;
        if (ctrl.ins_new)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (upd)
        begin
            case (cmd_reg.opcode)
                OP_LOOKUP: hit_next = stat.found;
                OP_LOWER:  hit_next = stat.any_sel;
                default:   hit_next = 1'b0;
            endcase
            dropped_next = is_insert && !stat.found && full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            hit_reg     <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            hit_reg     <= hit_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign count        = count_reg;
    assign hit          = hit_reg;
    assign dropped_full = dropped_reg;

endmodule
`default_nettype wire

FILE: design/skvt_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// skvt_checker
// Port-level checks on command beats and result timing of the table.
// ---------------------------------------------------------------------------
module skvt_checker
    import skvt_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t result
);

    logic accept;

    assign accept = start && !busy;

    // every command beat gets its result, after the compare and update states
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("result missing three cycles after command beat");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after command beat");

    // results are single-cycle strobes
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // a beat cannot both hit and be dropped
    a_hit_vs_drop: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.hit && result.dropped_full))
        else $error("result both hit and dropped");

endmodule

bind sorted_key_value_table skvt_checker u_skvt_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted key/value table: directed commands on
// the key and value extremes, then random phases that fill, churn and drain
// the table, with every result checked against a software copy of the table.
// ---------------------------------------------------------------------------
module tb_top;
    import skvt_pkg::*;

    localparam word_t KEY_MIN   = 32'sh8000_0000;
    localparam word_t KEY_MAX   = 32'sh7fff_ffff;
    localparam int    POOL_SIZE = 96;
    localparam int    IDLE_PCT  = 37;

    typedef enum int {
        KEYS_NARROW,
        KEYS_POOL,
        KEYS_WIDE
    } key_mode_t;

    typedef struct {
        int        n_items;
        key_mode_t key_mode;
        int        w_insert;
        int        w_remove;
        int        w_lookup;
        bit        idle_on;
    } phase_t;

    // copy of the table plus the results it predicts, oldest first
    class table_scoreboard;
        word_t       stored_key [CAPACITY];
        word_t       stored_val [CAPACITY];
        int unsigned n_pairs;
        rsp_t        pending_rsp[$];
        int          n_errors;
        int          n_by_op    [4];
        int          n_hits;
        int          n_drops;
        int          peak_pairs;

        function new();
            n_pairs    = 0;
            n_errors   = 0;
            n_hits     = 0;
            n_drops    = 0;
            peak_pairs = 0;
            foreach (n_by_op[i]) n_by_op[i] = 0;
        endfunction

        function int outstanding();
            return pending_rsp.size();
        endfunction

        function void note_command(cmd_t c);
            rsp_t        r;
            int unsigned idx;
            bit          found;
            idx = 0;
            while (idx < n_pairs && stored_key[idx] < c.key) idx++;
            found = (idx < n_pairs) && (stored_key[idx] == c.key);
            r = '0;
            case (c.opcode)
                OP_INSERT:
                begin
                    if (found)
                        stored_val[idx] = c.value;
                    else if (n_pairs >= CAPACITY)
                        r.dropped_full = 1'b1;
                    else
                    begin
                        for (int j = n_pairs; j > idx; j--)
                        begin
                            stored_key[j] = stored_key[j-1];
                            stored_val[j] = stored_val[j-1];
                        end
                        stored_key[idx] = c.key;
                        stored_val[idx] = c.value;
                        n_pairs++;
                    end
                end
                OP_REMOVE:
                begin
                    if (found)
                    begin
                        for (int j = idx; j < n_pairs - 1; j++)
                        begin
                            stored_key[j] = stored_key[j+1];
                            stored_val[j] = stored_val[j+1];
                        end
                        n_pairs--;
                    end
                end
                OP_LOOKUP:
                begin
                    if (found)
                    begin
                        r.hit          = 1'b1;
                        r.result_value = stored_val[idx];
                    end
                end
                default:
                begin
                    if (idx < n_pairs)
                    begin
                        r.hit          = 1'b1;
                        r.result_value = stored_val[idx];
                    end
                end
            endcase
            r.entry_count = COUNT_W'(n_pairs);
            n_by_op[c.opcode]++;
            if (r.hit) n_hits++;
            if (r.dropped_full) n_drops++;
            if (n_pairs > peak_pairs) peak_pairs = n_pairs;
            pending_rsp = {pending_rsp, r};
        endfunction

        function void report(string field, longint e, longint a);
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, a);
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp;
            if (pending_rsp.size() == 0)
            begin
                n_errors++;
                $display("%0t: result with no command outstanding, actual %h", $time, got);
                return;
            end
            exp = pending_rsp.pop_front();
            if (got.hit !== exp.hit) report("hit", exp.hit, got.hit);
            if (got.result_value !== exp.result_value)
                report("result_value", exp.result_value, got.result_value);
            if (got.dropped_full !== exp.dropped_full)
                report("dropped_full", exp.dropped_full, got.dropped_full);
            if (got.entry_count !== exp.entry_count)
                report("entry_count", exp.entry_count, got.entry_count);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t command = '0;
    logic busy;
    logic done;
    rsp_t result;

    table_scoreboard sb;
    word_t           key_pool[POOL_SIZE];

    sorted_key_value_table dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result of an older command is checked before a new beat is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done) sb.check_result(result);
            if (start && !busy) sb.note_command(command);
        end
    end

    task automatic send_command(opcode_t op, word_t k, word_t v, bit idle_on);
        cmd_t c;
        c.opcode = op;
        c.key    = k;
        c.value  = v;
        if (idle_on)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start   <= 1'b1;
        command <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    function automatic word_t pick_key(key_mode_t mode);
        case (mode)
            KEYS_NARROW:
            begin
                case ($urandom_range(15))
                    0:       return KEY_MIN;
                    1:       return KEY_MAX;
                    default: return word_t'($urandom_range(12)) - 6;
                endcase
            end
            KEYS_POOL: return key_pool[$urandom_range(POOL_SIZE - 1)];
            default:
            begin
                if ($urandom_range(1)) return key_pool[$urandom_range(POOL_SIZE - 1)];
                return word_t'($urandom);
            end
        endcase
    endfunction

    function automatic word_t pick_value();
        case ($urandom_range(15))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return '0;
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic opcode_t pick_op(phase_t ph);
        int r;
        r = $urandom_range(99);
        if (r < ph.w_insert) return OP_INSERT;
        if (r < ph.w_insert + ph.w_remove) return OP_REMOVE;
        if (r < ph.w_insert + ph.w_remove + ph.w_lookup) return OP_LOOKUP;
        return OP_LOWER;
    endfunction

    initial
    begin
        phase_t phases[6];
        sb = new();
        phases[0] = '{200, KEYS_NARROW, 30, 25, 25, 1'b1};
        phases[1] = '{200, KEYS_POOL,   70, 10, 10, 1'b1};
        phases[2] = '{250, KEYS_POOL,   30, 25, 25, 1'b0};
        phases[3] = '{200, KEYS_POOL,   10, 60, 15, 1'b1};
        phases[4] = '{200, KEYS_WIDE,   40, 20, 20, 1'b1};
        phases[5] = '{150, KEYS_NARROW, 25, 25, 10, 1'b1};
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = -1;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = word_t'($urandom);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // empty table
        send_command(OP_LOOKUP, 5, 0, 1'b1);
        send_command(OP_LOWER,  5, 0, 1'b1);
        send_command(OP_REMOVE, 5, 0, 1'b1);
        // extremes, then an overwrite of an existing key
        send_command(OP_INSERT, KEY_MIN, KEY_MAX, 1'b0);
        send_command(OP_INSERT, KEY_MAX, KEY_MIN, 1'b0);
        send_command(OP_INSERT, 0, 0, 1'b0);
        send_command(OP_INSERT, -1, 32'sh5555_5555, 1'b1);
        send_command(OP_INSERT, 0, 32'shaaaa_aaaa, 1'b1);
        send_command(OP_LOOKUP, KEY_MIN, 0, 1'b1);
        send_command(OP_LOOKUP, KEY_MAX, 0, 1'b0);
        send_command(OP_LOOKUP, 0, 0, 1'b0);
        send_command(OP_LOOKUP, 7, 0, 1'b1);
        send_command(OP_LOWER,  KEY_MIN, 0, 1'b0);
        send_command(OP_LOWER,  1, 0, 1'b1);
        send_command(OP_LOWER,  -2, 0, 1'b0);
        send_command(OP_LOWER,  KEY_MAX, 0, 1'b1);
        // absent remove, then lower-bound past the largest key
        send_command(OP_REMOVE, 100, 0, 1'b0);
        send_command(OP_REMOVE, KEY_MAX, 0, 1'b1);
        send_command(OP_LOWER,  KEY_MAX, 0, 1'b0);
        send_command(OP_LOOKUP, KEY_MAX, 0, 1'b0);
        send_command(OP_REMOVE, KEY_MIN, 0, 1'b1);
        send_command(OP_REMOVE, -1, 0, 1'b0);
        send_command(OP_REMOVE, 0, 0, 1'b1);
        send_command(OP_LOWER,  KEY_MIN, 0, 1'b0);
        wait_drained();

        foreach (phases[p])
        begin
            for (int i = 0; i < phases[p].n_items; i++)
                send_command(pick_op(phases[p]), pick_key(phases[p].key_mode),
                             pick_value(), phases[p].idle_on);
            // hold off until the table has answered everything
            wait_drained();
        end

        repeat (8) @(posedge clk);
        $display("covered %0d inserts, %0d removes, %0d lookups, %0d lower-bounds",
                 sb.n_by_op[OP_INSERT], sb.n_by_op[OP_REMOVE],
                 sb.n_by_op[OP_LOOKUP], sb.n_by_op[OP_LOWER]);
        $display("%0d hits, %0d full-table drops, peak of %0d pairs, %0d errors",
                 sb.n_hits, sb.n_drops, sb.peak_pairs, sb.n_errors);
        if (sb.n_errors == 0 && sb.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("timeout with %0d results outstanding", sb.outstanding());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sorted_key_value_table.f
design/skvt_pkg.sv
design/skvt_cell.sv
design/skvt_gather.sv
design/skvt_ctrl.sv
design/sorted_key_value_table.sv
design/skvt_checker.sv
tb/sv/tb_top.sv
